// ===== hw/rtl/adam_pkg.sv =====
// Shared types and constants for the fixed-point Adam update block.
// Used by adam_mem, adam_divsqrt and adam_optimizer_update; depends on nothing.
package adam_pkg;

    localparam int SLOT_COUNT_DEF = 4096;

    // Field widths
    localparam int PW   = 32;   // Q8.24 parameter and gradient
    localparam int SW   = 12;   // slot field
    localparam int CFGW = 24;   // configuration data
    localparam int MW   = 48;   // one moment entry
    localparam int MEMW = 2 * MW;

    // Configuration register indexes
    localparam logic [1:0] CFG_BETA_ONE   = 2'd0;
    localparam logic [1:0] CFG_BETA_TWO   = 2'd1;
    localparam logic [1:0] CFG_LEARN_RATE = 2'd2;

    localparam logic [23:0] BETA_ONE_RST   = 24'd15099494;
    localparam logic [23:0] BETA_TWO_RST   = 24'd16760439;
    localparam logic [23:0] LEARN_RATE_RST = 24'd16777;

    localparam logic [24:0] Q24_ONE   = 25'h1000000;
    localparam logic [52:0] EPS_Q32   = 53'd43;       // 1e-8 in Q.32
    localparam logic [33:0] DELTA_CAP = 34'h200000000;

    // Divide / square root unit
    localparam int DSQ_NW = 104;  // dividend / radicand
    localparam int DSQ_DW = 53;   // divisor
    localparam int DSQ_RW = 56;   // partial remainder
    localparam int DSQ_SW = 52;   // root
    localparam int DSQ_CW = 7;
    localparam logic [DSQ_CW-1:0] DSQ_DIV_STEPS  = 7'd104;
    localparam logic [DSQ_CW-1:0] DSQ_SQRT_STEPS = 7'd52;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_dsq_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dsq_stat;

endpackage

// ===== hw/rtl/adam_mem.sv =====
// Moment storage: one synchronous RAM holding {first, second} moment per slot.
// Registered read, one write port; widths from adam_pkg.
module adam_mem #(
    parameter int DEPTH = adam_pkg::SLOT_COUNT_DEF,
    parameter int AW    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [adam_pkg::MEMW-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [adam_pkg::MEMW-1:0] o_rdata
);

    logic [adam_pkg::MEMW-1:0] r_mem [DEPTH];
    logic [adam_pkg::MEMW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/adam_divsqrt.sv =====
// Shared bit-serial unit: restoring divide (one quotient bit per cycle) or
// digit-by-digit integer square root (one root bit per cycle). Uses adam_pkg.
module adam_divsqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  adam_pkg::t_dsq_req          i_req,
    input  logic [adam_pkg::DSQ_NW-1:0] i_oper,
    input  logic [adam_pkg::DSQ_DW-1:0] i_divisor,
    output adam_pkg::t_dsq_stat         o_stat,
    output logic [adam_pkg::DSQ_NW-1:0] o_result
);

    localparam int NW = adam_pkg::DSQ_NW;
    localparam int DW = adam_pkg::DSQ_DW;
    localparam int RW = adam_pkg::DSQ_RW;
    localparam int QW = adam_pkg::DSQ_SW;
    localparam int CW = adam_pkg::DSQ_CW;

    logic                       r_busy;
    logic                       r_done;
    logic                       r_sqrt;
    logic [adam_pkg::DSQ_CW-1:0] r_cnt;
    logic [NW-1:0]              r_n;
    logic [RW-1:0]              r_rem;
    logic [QW-1:0]              r_root;
    logic [DW-1:0]              r_div;

    logic [RW-1:0] trial;
    logic [RW-1:0] sub;
    logic          ge;

    always_comb begin
        if (r_sqrt) begin
            trial = {r_rem[RW-3:0], r_n[NW-1 -: 2]};
            sub   = {2'b00, r_root, 2'b01};
        end else begin
            trial = {r_rem[RW-2:0], r_n[NW-1]};
            sub   = {{(RW-DW){1'b0}}, r_div};
        end
        ge = (trial >= sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_cnt  <= i_req.is_sqrt ? adam_pkg::DSQ_SQRT_STEPS
                                        : adam_pkg::DSQ_DIV_STEPS;
                r_n    <= i_oper;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? (trial - sub) : trial;
                if (r_sqrt) begin
                    r_root <= {r_root[QW-2:0], ge};
                    r_n    <= {r_n[NW-3:0], 2'b00};
                end else begin
                    r_n <= {r_n[NW-2:0], ge};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_sqrt ? {{(NW-QW){1'b0}}, r_root} : r_n;

endmodule

// ===== hw/rtl/adam_optimizer_update.sv =====
// Element-wise Adam update in fixed point.
// Input channel (i_in_valid / o_in_stall) carries one parameter, its gradient,
// a slot number and a last-of-call flag. The output channel
// (o_out_valid / i_out_stall) returns the updated parameter and the slot.
// The configuration port writes beta_one, beta_two and learn_rate; writing a
// decay rate also restarts its running power (bias correction back to step 1).
// After reset the moment RAM is swept to zero, one slot per cycle; o_in_stall is
// high during the sweep.
// One item is in work at a time. From accept to result an item goes through
// slot reduction, multiplies on one shared 32x32 multiplier and the moment
// RAM read/write, then three 104-step divides and one 52-step square root on the
// shared bit-serial unit, and an advance of the powers when the item closes a
// call. The next item is taken in the cycle after the result is loaded; the
// divide/sqrt unit takes most of the time per item.
// The result sits in an output register; when the receiver stalls it holds,
// and the block still accepts the next item, stopping only if a new result
// is ready before the old one is taken.
// Depends on adam_pkg, adam_mem, adam_divsqrt.
module adam_optimizer_update #(
    parameter int SLOT_COUNT = adam_pkg::SLOT_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [31:0]        i_param_value,
    input  logic signed [31:0]        i_gradient,
    input  logic [11:0]               i_slot,
    input  logic                      i_last_of_call,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [31:0]        o_new_param_value,
    output logic [11:0]               o_slot_echo,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [23:0]               i_cfg_data
);

    localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RECIP = (1 << 24) / SLOT_COUNT;
    localparam int MW    = adam_pkg::MW;
    localparam int NW    = adam_pkg::DSQ_NW;
    localparam int DW    = adam_pkg::DSQ_DW;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_MOD1, S_MOD2, S_MOD3, S_RD,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10, S_M11,
        S_D1S, S_D1W, S_D2S, S_D2W, S_SQS, S_SQW, S_D3S, S_D3W,
        S_PW0, S_PW1, S_PW2, S_OUT
    } t_state;

    t_state r_state;

    // configuration and running powers
    logic [23:0] r_b1, r_b2, r_lr, r_pw1, r_pw2;

    // item
    logic signed [31:0] r_p;
    logic [11:0]        r_slot;
    logic               r_last;
    logic               r_gneg;
    logic [31:0]        r_gmag;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_clr;

    // datapath
    logic [63:0]        r_prod;
    logic [MW-1:0]      r_amag;
    logic               r_mneg;
    logic [MW-1:0]      r_vold;
    logic [49:0]        r_t;
    logic signed [49:0] r_macc;
    logic signed [MW-1:0] r_m;
    logic [MW-1:0]      r_v;
    logic [MW-1:0]      r_vacc;
    logic [MW-1:0]      r_gsq;
    logic [87:0]        r_num;
    logic [NW-1:0]      r_q1;
    logic [DW-1:0]      r_den;
    logic [33:0]        r_delta;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_param;
    logic [11:0]        r_out_slot;

    logic [31:0] mul_a, mul_b;
    logic [24:0] c1, c2, d1, d2;
    logic [MW-1:0] mmag;
    logic [71:0] num72;
    logic [11:0] slot_r;
    logic [31:0] idx_wide;
    logic signed [49:0] t1s, t2s, msum;
    logic signed [34:0] diff;
    logic signed [31:0] sat;

    // memory and divide unit hookup
    logic                      mem_we, mem_re;
    logic [IW-1:0]             mem_waddr;
    logic [adam_pkg::MEMW-1:0] mem_wdata, mem_rdata;
    adam_pkg::t_dsq_req        dsq_req;
    adam_pkg::t_dsq_stat       dsq_stat;
    logic [NW-1:0]             dsq_oper, dsq_res;
    logic [DW-1:0]             dsq_div;

    assign c1 = adam_pkg::Q24_ONE - {1'b0, r_b1};
    assign c2 = adam_pkg::Q24_ONE - {1'b0, r_b2};
    assign d1 = adam_pkg::Q24_ONE - {1'b0, r_pw1};
    assign d2 = adam_pkg::Q24_ONE - {1'b0, r_pw2};
    assign mmag = r_m[MW-1] ? MW'(-r_m) : MW'(r_m);
    assign num72 = {r_t[47:0], 24'b0} + {24'b0, r_prod[47:0]};

    // slot modulo SLOT_COUNT: reciprocal estimate is low by at most one
    assign slot_r   = r_slot - r_prod[11:0];
    assign idx_wide = (32'(slot_r) >= 32'(SLOT_COUNT)) ? 32'(slot_r) - 32'(SLOT_COUNT)
                                                       : 32'(slot_r);

    assign t1s  = r_mneg ? -$signed(r_t) : $signed(r_t);
    assign t2s  = r_gneg ? -$signed(r_t) : $signed(r_t);
    assign msum = r_macc + t2s;

    assign diff = r_m[MW-1] ? (35'(r_p) + $signed({1'b0, r_delta}))
                            : (35'(r_p) - $signed({1'b0, r_delta}));
    always_comb begin
        if (diff > 35'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (diff < -35'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = diff[31:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MOD1: begin mul_a = 32'(r_slot);           mul_b = 32'(RECIP); end
            S_MOD2: begin mul_a = 32'(r_prod[35:24]);    mul_b = 32'(SLOT_COUNT); end
            S_M0:   begin mul_a = 32'(r_amag[47:24]);    mul_b = 32'(r_b1); end
            S_M1:   begin mul_a = 32'(r_amag[23:0]);     mul_b = 32'(r_b1); end
            S_M2:   begin mul_a = 32'(r_gmag[31:8]);     mul_b = 32'(c1); end
            S_M3:   begin mul_a = 32'({r_gmag[7:0], 16'b0}); mul_b = 32'(c1); end
            S_M4:   begin mul_a = r_gmag;                mul_b = r_gmag; end
            S_M5:   begin mul_a = 32'(r_vold[47:24]);    mul_b = 32'(r_b2); end
            S_M6:   begin mul_a = 32'(r_vold[23:0]);     mul_b = 32'(r_b2); end
            S_M7:   begin mul_a = 32'(r_gsq[47:24]);     mul_b = 32'(c2); end
            S_M8:   begin mul_a = 32'(r_gsq[23:0]);      mul_b = 32'(c2); end
            S_M9:   begin mul_a = 32'(r_lr);             mul_b = 32'(mmag[47:24]); end
            S_M10:  begin mul_a = 32'(r_lr);             mul_b = 32'(mmag[23:0]); end
            S_PW0:  begin mul_a = 32'(r_pw1);            mul_b = 32'(r_b1); end
            S_PW1:  begin mul_a = 32'(r_pw2);            mul_b = 32'(r_b2); end
            default: begin mul_a = '0;                   mul_b = '0; end
        endcase
    end

    // divide / sqrt requests
    always_comb begin
        dsq_req.start   = 1'b0;
        dsq_req.is_sqrt = 1'b0;
        dsq_oper        = '0;
        dsq_div         = '0;
        unique case (r_state)
            S_D1S: begin
                dsq_req.start = 1'b1;
                dsq_oper      = {16'b0, r_num};
                dsq_div       = DW'(d1);
            end
            S_D2S: begin
                dsq_req.start = 1'b1;
                dsq_oper      = {1'b0, r_v, 55'b0};
                dsq_div       = DW'(d2);
            end
            S_SQS: begin
                dsq_req.start   = 1'b1;
                dsq_req.is_sqrt = 1'b1;
                dsq_oper        = dsq_res;
            end
            S_D3S: begin
                dsq_req.start = 1'b1;
                dsq_oper      = r_q1;
                dsq_div       = r_den;
            end
            default: begin
                dsq_req.start = 1'b0;
            end
        endcase
    end

    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_M10);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : r_idx;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : {r_m, r_v};
    assign mem_re    = (r_state == S_MOD3);

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_b1        <= adam_pkg::BETA_ONE_RST;
            r_b2        <= adam_pkg::BETA_TWO_RST;
            r_lr        <= adam_pkg::LEARN_RATE_RST;
            r_pw1       <= adam_pkg::BETA_ONE_RST;
            r_pw2       <= adam_pkg::BETA_TWO_RST;
        end else begin
            // S_OUT sets the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    adam_pkg::CFG_BETA_ONE:   begin r_b1 <= i_cfg_data; r_pw1 <= i_cfg_data; end
                    adam_pkg::CFG_BETA_TWO:   begin r_b2 <= i_cfg_data; r_pw2 <= i_cfg_data; end
                    adam_pkg::CFG_LEARN_RATE: r_lr <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(SLOT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_p     <= i_param_value;
                        r_slot  <= i_slot;
                        r_last  <= i_last_of_call;
                        r_gneg  <= i_gradient[31];
                        r_gmag  <= i_gradient[31] ? 32'(-i_gradient) : 32'(i_gradient);
                        r_state <= S_MOD1;
                    end
                end
                S_MOD1: r_state <= S_MOD2;
                S_MOD2: r_state <= S_MOD3;
                S_MOD3: begin
                    r_idx   <= idx_wide[IW-1:0];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_mneg  <= mem_rdata[2*MW-1];
                    r_amag  <= mem_rdata[2*MW-1] ? MW'(-mem_rdata[2*MW-1:MW])
                                                 : mem_rdata[2*MW-1:MW];
                    r_vold  <= mem_rdata[MW-1:0];
                    r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_t     <= 50'(r_prod[48:0]);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_t     <= r_t + 50'(r_prod[48:24]);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_macc  <= t1s;
                    r_t     <= 50'(r_prod[48:0]);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_t     <= r_t + 50'(r_prod[48:24]);
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_gsq   <= r_prod[62:15];
                    r_m     <= msum[MW-1:0];
                    r_state <= S_M6;
                end
                S_M6: begin
                    r_t     <= 50'(r_prod[48:0]);
                    r_state <= S_M7;
                end
                S_M7: begin
                    r_t     <= r_t + 50'(r_prod[48:24]);
                    r_state <= S_M8;
                end
                S_M8: begin
                    r_vacc  <= r_t[MW-1:0];
                    r_t     <= 50'(r_prod[48:0]);
                    r_state <= S_M9;
                end
                S_M9: begin
                    r_v     <= r_vacc + r_t[MW-1:0] + MW'(r_prod[48:24]);
                    r_state <= S_M10;
                end
                S_M10: begin
                    r_t     <= 50'(r_prod[47:0]);
                    r_state <= S_M11;
                end
                S_M11: begin
                    r_num   <= {num72, 16'b0};
                    r_state <= S_D1S;
                end
                S_D1S: r_state <= S_D1W;
                S_D1W: begin
                    if (dsq_stat.done) begin
                        r_q1    <= dsq_res;
                        r_state <= S_D2S;
                    end
                end
                S_D2S: r_state <= S_D2W;
                S_D2W: begin
                    if (dsq_stat.done) begin
                        r_state <= S_SQS;
                    end
                end
                S_SQS: r_state <= S_SQW;
                S_SQW: begin
                    if (dsq_stat.done) begin
                        r_den   <= DW'(dsq_res[adam_pkg::DSQ_SW-1:0]) + adam_pkg::EPS_Q32;
                        r_state <= S_D3S;
                    end
                end
                S_D3S: r_state <= S_D3W;
                S_D3W: begin
                    if (dsq_stat.done) begin
                        if ((|dsq_res[NW-1:34]) || (dsq_res[33:0] > adam_pkg::DELTA_CAP)) begin
                            r_delta <= adam_pkg::DELTA_CAP;
                        end else begin
                            r_delta <= dsq_res[33:0];
                        end
                        r_state <= r_last ? S_PW0 : S_OUT;
                    end
                end
                S_PW0: r_state <= S_PW1;
                S_PW1: begin
                    r_pw1   <= r_prod[47:24];
                    r_state <= S_PW2;
                end
                S_PW2: begin
                    r_pw2   <= r_prod[47:24];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_param <= sat;
                        r_out_slot  <= r_slot;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    adam_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx_wide[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    adam_divsqrt u_dsq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dsq_req),
        .i_oper    (dsq_oper),
        .i_divisor (dsq_div),
        .o_stat    (dsq_stat),
        .o_result  (dsq_res)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_new_param_value = r_out_param;
    assign o_slot_echo       = r_out_slot;

endmodule

// ===== hw/rtl/adam_checker.sv =====
// Port-level checks for adam_optimizer_update, attached by bind.
// Sees only the top-level ports; no package use.
module adam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_new_param_value,
    input logic [11:0] o_slot_echo
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one item at a time: an accept closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

    // a result appears only while the input side is closed for its item
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_new_param_value)
            && $stable(o_slot_echo))
        else $error("stalled result changed");

endmodule

bind adam_optimizer_update adam_checker u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_new_param_value (o_new_param_value),
    .o_slot_echo       (o_slot_echo)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for adam_optimizer_update: a queue-fed driver, a stalling
// monitor and a bit-exact fixed-point Adam predictor. Depends on adam_pkg and the RTL.
module tb_top;

    localparam int          SLOTS      = 4096;
    localparam int          CYCLE_CAP  = 20000000;
    localparam int          DRAIN_WAIT = 600;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam logic [23:0] Q24_MAX    = 24'hFFFFFF;

    typedef struct {
        logic signed [31:0] param;
        logic signed [31:0] grad;
        logic [11:0]        slot;
        logic               last;
    } t_adam_item;

    typedef struct {
        logic signed [31:0] new_param;
        logic [11:0]        slot;
    } t_adam_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_param_value = '0;
    logic signed [31:0] i_gradient = '0;
    logic [11:0] i_slot = '0;
    logic i_last_of_call = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_new_param_value;
    logic [11:0] o_slot_echo;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    adam_optimizer_update uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [23:0] beta1_q, beta2_q, lrate_q, beta1_pow, beta2_pow;
    logic signed [63:0] m_store [SLOTS];
    logic [63:0] v_store [SLOTS];

    t_adam_item   item_fifo [$];
    t_adam_result result_fifo [$];
    int errors = 0, n_accepted = 0, n_checked = 0, n_cfg = 0;
    bit idling_on = 1'b1;
    longint cycles = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 20);
        return $urandom_range(100, 800);
    endfunction

    function automatic logic [63:0] mul_q24(input logic [63:0] a, input logic [24:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {103'd0, b};
        return prod[87:24];
    endfunction

    function automatic logic signed [63:0] mul_q24_s(input logic signed [63:0] a,
                                                    input logic [24:0] b);
        logic [63:0] mag, r;
        mag = a[63] ? -a : a;
        r = mul_q24(mag, b);
        return a[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic void predict_update(input t_adam_item it);
        logic [24:0] c1, c2;
        logic [63:0] gmag, v, mmag, den, root, cand, delta;
        logic signed [63:0] m, res;
        logic [127:0] vh, num, q, csq;
        logic [11:0] idx;
        t_adam_result exp_res;
        idx = it.slot % SLOTS;
        c1 = adam_pkg::Q24_ONE - beta1_q;
        c2 = adam_pkg::Q24_ONE - beta2_q;
        gmag = it.grad[31] ? -64'(it.grad) : 64'(it.grad);
        m = mul_q24_s(m_store[idx], {1'b0, beta1_q})
          + mul_q24_s(64'(it.grad) * 64'sd65536, c1);
        v = mul_q24(v_store[idx], {1'b0, beta2_q}) + mul_q24((gmag * gmag) >> 15, c2);
        m_store[idx] = m;
        v_store[idx] = v;

        vh = ({64'd0, v} << 55) / (adam_pkg::Q24_ONE - beta2_pow);
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            csq = {64'd0, cand} * {64'd0, cand};
            if (csq <= vh) root = cand;
        end
        den = root + 64'd43;

        mmag = m[63] ? -m : m;
        num = ({104'd0, lrate_q} * {64'd0, mmag}) << 16;
        q = num / (adam_pkg::Q24_ONE - beta1_pow);
        q = q / {64'd0, den};
        delta = (q > 128'(adam_pkg::DELTA_CAP)) ? 64'(adam_pkg::DELTA_CAP) : q[63:0];
        res = m[63] ? 64'(it.param) + $signed(delta) : 64'(it.param) - $signed(delta);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;

        if (it.last) begin
            beta1_pow = 24'(({24'd0, beta1_pow} * {24'd0, beta1_q}) >> 24);
            beta2_pow = 24'(({24'd0, beta2_pow} * {24'd0, beta2_q}) >> 24);
        end
        exp_res.new_param = res[31:0];
        exp_res.slot = it.slot;
        result_fifo.insert(result_fifo.size(), exp_res);
    endfunction

    // driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (i_in_valid) begin
                predict_update('{i_param_value, i_gradient, i_slot, i_last_of_call});
                n_accepted++;
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (item_fifo.size() > 0) begin
                t_adam_item it;
                it = item_fifo.pop_front();
                i_param_value <= it.param;
                i_gradient <= it.grad;
                i_slot <= it.slot;
                i_last_of_call <= it.last;
                i_in_valid <= 1'b1;
                in_gap <= (idling_on && $urandom_range(2) == 0) ? gap_len() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result param=%h slot=%h", $time,
                             o_new_param_value, o_slot_echo);
                    errors++;
                end else begin
                    t_adam_result e;
                    e = result_fifo.pop_front();
                    n_checked++;
                    if (o_new_param_value !== e.new_param) begin
                        $display("%0t: new_param_value expected %h actual %h", $time,
                                 e.new_param, o_new_param_value);
                        errors++;
                    end
                    if (o_slot_echo !== e.slot) begin
                        $display("%0t: slot_echo expected %h actual %h", $time,
                                 e.slot, o_slot_echo);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (idling_on && $urandom_range(9) < 3) stall_left <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        unique case (idx)
            adam_pkg::CFG_BETA_ONE: begin
                beta1_q = val;
                beta1_pow = val;
            end
            adam_pkg::CFG_BETA_TWO: begin
                beta2_q = val;
                beta2_pow = val;
            end
            adam_pkg::CFG_LEARN_RATE: lrate_q = val;
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [23:0] b1, input logic [23:0] b2,
                            input logic [23:0] lr);
        cfg_write(adam_pkg::CFG_BETA_ONE, b1);
        cfg_write(adam_pkg::CFG_BETA_TWO, b2);
        cfg_write(adam_pkg::CFG_LEARN_RATE, lr);
    endtask

    task automatic drain();
        while (item_fifo.size() > 0 || i_in_valid || result_fifo.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push_item(input logic [31:0] p, input logic [31:0] g,
                             input logic [11:0] s, input logic l);
        item_fifo.insert(item_fifo.size(), '{p, g, s, l});
    endtask

    // mostly a small working set of slots so moments build up over many steps
    task automatic push_random(input int n);
        logic [31:0] p, g;
        logic [11:0] s;
        for (int i = 0; i < n; i++) begin
            p = $urandom;
            if ($urandom_range(3) == 0) p = $signed(p) >>> $urandom_range(20);
            case ($urandom_range(3))
                0: g = $urandom;
                1: g = $signed($urandom) >>> $urandom_range(4, 24);
                2: g = $signed($urandom) >>> $urandom_range(24, 31);
                default: g = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            endcase
            s = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
            push_item(p, g, s, $urandom_range(7) == 0);
        end
    endtask

    initial begin
        beta1_q = adam_pkg::BETA_ONE_RST;
        beta2_q = adam_pkg::BETA_TWO_RST;
        lrate_q = adam_pkg::LEARN_RATE_RST;
        beta1_pow = adam_pkg::BETA_ONE_RST;
        beta2_pow = adam_pkg::BETA_TWO_RST;
        for (int i = 0; i < SLOTS; i++) begin
            m_store[i] = '0;
            v_store[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: field extremes, zero gradient, slot edges, call boundaries
        push_item(32'h0000_0000, 32'h0000_0000, 12'd0, 1'b0);
        push_item(32'h7FFF_FFFF, 32'h8000_0000, 12'd4095, 1'b0);
        push_item(32'h8000_0000, 32'h7FFF_FFFF, 12'd4095, 1'b1);
        push_item(32'h0100_0000, 32'h0100_0000, 12'd1, 1'b0);
        push_item(32'hFF00_0000, 32'hFFFF_FFFF, 12'd1, 1'b1);
        push_item(32'h7FFF_FFFF, 32'h0000_0001, 12'd2, 1'b0);
        push_item(32'h8000_0000, 32'hFFFF_FFFF, 12'd2, 1'b1);
        push_item(32'h1234_5678, 32'h0000_0000, 12'd3, 1'b1);
        drain();

        // ignored index, then decay rates at zero and a maximal step size
        cfg_write(CFG_UNUSED, 24'hABCDEF);
        set_regs(24'd0, 24'd0, Q24_MAX);
        push_item(32'h7FFF_FFFF, 32'h8000_0000, 12'd5, 1'b0);
        push_item(32'h8000_0000, 32'h7FFF_FFFF, 12'd6, 1'b1);
        push_item(32'h0000_0000, 32'h0000_0001, 12'd7, 1'b0);
        push_random(150);
        drain();

        // decay rates at the top: tiny bias-correction divisors, huge updates
        set_regs(Q24_MAX, Q24_MAX, Q24_MAX);
        push_item(32'h7FFF_FFFF, 32'h8000_0000, 12'd8, 1'b0);
        push_item(32'h8000_0000, 32'h7FFF_FFFF, 12'd9, 1'b1);
        push_item(32'h8000_0000, 32'h0000_0001, 12'd10, 1'b1);
        push_random(150);
        drain();

        set_regs(24'($urandom), 24'($urandom), 24'($urandom));
        push_random(200);
        drain();

        set_regs(24'($urandom), 24'($urandom), 24'd0);
        push_random(100);
        drain();

        set_regs(24'($urandom), 24'($urandom), 24'($urandom_range(1 << 16)));
        push_random(150);
        drain();

        // back to reset values, first without any idling
        idling_on = 1'b0;
        set_regs(adam_pkg::BETA_ONE_RST, adam_pkg::BETA_TWO_RST, adam_pkg::LEARN_RATE_RST);
        push_random(150);
        drain();
        idling_on = 1'b1;
        push_random(250);
        drain();

        $display("%0d items accepted, %0d results checked, %0d register writes",
                 n_accepted, n_checked, n_cfg);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/adam_pkg.sv
hw/rtl/adam_mem.sv
hw/rtl/adam_divsqrt.sv
hw/rtl/adam_optimizer_update.sv
hw/rtl/adam_checker.sv
tb/tb_top.sv
